[sv/wdps_pkg.sv]
// Shared types, constants and helpers of the weighted deficit path selector.
`default_nettype none
package wdps_pkg;

  localparam int NUM_WEIGHT_REGS = 8;
  localparam int WEIGHT_W        = 10;
  localparam int DEF_W           = 32;
  localparam int STEP_W          = 14;
  localparam int QUANTUM         = 1500;
  localparam int DEFAULT_WEIGHT  = 100;
  localparam int MAX_WEIGHT      = 1000;

  typedef logic [NUM_WEIGHT_REGS-1:0][WEIGHT_W-1:0] weight_arr_t;

  typedef enum logic [1:0] {
    ST_DEFICIT   = 2'd0,
    ST_FALLBACK  = 2'd1,
    ST_NO_ACTIVE = 2'd2,
    ST_PTR_RESET = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_CHARGE,
    S_CLEAR,
    S_FINISH
  } state_t;

  // 15 times the effective weight; out-of-range weights count as the default
  function automatic logic [STEP_W-1:0] weight_step(input logic [WEIGHT_W-1:0] w);
    logic [WEIGHT_W-1:0] e;
    e = (w == '0 || w > WEIGHT_W'(MAX_WEIGHT)) ? WEIGHT_W'(DEFAULT_WEIGHT) : w;
    return STEP_W'({4'b0, e} * STEP_W'(QUANTUM / DEFAULT_WEIGHT));
  endfunction

endpackage
`default_nettype wire

[sv/weighted_deficit_path_selector_unit.sv]
// Top level: deficit round-robin path selector with scan sequencer.
//
// Each request is taken in the idle state and the block is busy until its
// result is loaded into the output register. A pointer-reset request or a
// request with no active path goes straight to the finish state. A choose
// request scans the paths one per cycle through a single shared saturating
// adder, starting at the round-robin pointer: a hit goes to the charge
// state, and a full circle with no positive deficit goes to the clear state,
// which clears all deficits and picks the lowest active path. The output
// register lets a new request enter while a result is still waiting.
`default_nettype none
module weighted_deficit_path_selector_unit #(
  parameter int NUM_PATHS = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        req_type,
  input  wire logic [7:0]  active_mask,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       status,
  output logic [2:0]       path_index,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int IW = $clog2(NUM_PATHS);

  wdps_pkg::weight_arr_t  weights;
  wdps_pkg::state_t       state, state_next;

  logic [IW-1:0]          idx, idx_next, idx_inc;
  logic [IW-1:0]          cnt, cnt_next;
  logic [IW-1:0]          rr_ptr, rr_ptr_next;
  logic [IW-1:0]          lowest;
  logic [NUM_PATHS-1:0]   mask_q, mask_q_next;
  logic signed [31:0]     acc, acc_next;
  logic signed [31:0]     deficit [NUM_PATHS];
  logic signed [31:0]     deficit_next [NUM_PATHS];
  wdps_pkg::status_t      res_status, res_status_next;
  logic [IW-1:0]          res_path, res_path_next;
  logic                   out_valid_next;
  logic [1:0]             status_next;
  logic [2:0]             path_index_next;
  logic signed [31:0]     alu_a, alu_b, alu_sum;

  wdps_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .weights (weights)
  );

  wdps_alu u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .sum (alu_sum)
  );

  assign idx_inc = (idx == IW'(NUM_PATHS - 1)) ? '0 : idx + 1'b1;

  always_comb begin
    lowest = '0;
    for (int i = NUM_PATHS - 1; i >= 0; i--) begin
      if (mask_q[i]) lowest = IW'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= wdps_pkg::S_IDLE;
      rr_ptr    <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < NUM_PATHS; i++) begin
        deficit[i] <= '0;
      end
    end else begin
      state     <= state_next;
      rr_ptr    <= rr_ptr_next;
      out_valid <= out_valid_next;
      deficit   <= deficit_next;
    end
  end

  always_ff @(posedge clk) begin
    idx        <= idx_next;
    cnt        <= cnt_next;
    mask_q     <= mask_q_next;
    acc        <= acc_next;
    res_status <= res_status_next;
    res_path   <= res_path_next;
    status     <= status_next;
    path_index <= path_index_next;
  end

  always_comb begin
    state_next      = state;
    idx_next        = idx;
    cnt_next        = cnt;
    rr_ptr_next     = rr_ptr;
    mask_q_next     = mask_q;
    acc_next        = acc;
    deficit_next    = deficit;
    res_status_next = res_status;
    res_path_next   = res_path;
    status_next     = status;
    path_index_next = path_index;
    out_valid_next  = out_valid && !out_ready;
    in_ready        = 1'b0;
    alu_a           = deficit[idx];
    alu_b           = $signed({18'b0, wdps_pkg::weight_step(weights[3'(idx)])});

    unique case (state)
      wdps_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (req_type) begin
            rr_ptr_next     = '0;
            res_status_next = wdps_pkg::ST_PTR_RESET;
            res_path_next   = '0;
            state_next      = wdps_pkg::S_FINISH;
          end else if (active_mask[NUM_PATHS-1:0] == '0) begin
            res_status_next = wdps_pkg::ST_NO_ACTIVE;
            res_path_next   = '0;
            state_next      = wdps_pkg::S_FINISH;
          end else begin
            mask_q_next = active_mask[NUM_PATHS-1:0];
            idx_next    = rr_ptr;
            cnt_next    = '0;
            state_next  = wdps_pkg::S_SCAN;
          end
        end
      end
      wdps_pkg::S_SCAN: begin
        if (mask_q[idx] && alu_sum > 0) begin
          acc_next   = alu_sum;
          state_next = wdps_pkg::S_CHARGE;
        end else begin
          if (mask_q[idx]) deficit_next[idx] = alu_sum;
          if (cnt == IW'(NUM_PATHS - 1)) begin
            state_next = wdps_pkg::S_CLEAR;
          end else begin
            idx_next = idx_inc;
            cnt_next = cnt + 1'b1;
          end
        end
      end
      wdps_pkg::S_CHARGE: begin
        alu_a             = acc;
        alu_b             = -32'sd1500;
        deficit_next[idx] = alu_sum;
        rr_ptr_next       = idx_inc;
        res_status_next   = wdps_pkg::ST_DEFICIT;
        res_path_next     = idx;
        state_next        = wdps_pkg::S_FINISH;
      end
      wdps_pkg::S_CLEAR: begin
        for (int i = 0; i < NUM_PATHS; i++) begin
          deficit_next[i] = '0;
        end
        res_status_next = wdps_pkg::ST_FALLBACK;
        res_path_next   = lowest;
        state_next      = wdps_pkg::S_FINISH;
      end
      wdps_pkg::S_FINISH: begin
        if (!out_valid || out_ready) begin
          out_valid_next  = 1'b1;
          status_next     = res_status;
          path_index_next = 3'(res_path);
          state_next      = wdps_pkg::S_IDLE;
        end
      end
      default: state_next = wdps_pkg::S_IDLE;
    endcase
  end

  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    rr_ptr <= IW'(NUM_PATHS - 1))
    else $error("round-robin pointer out of range");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted while busy");

  a_clear_done: assert property (@(posedge clk) disable iff (rst)
    state == wdps_pkg::S_CLEAR |=> deficit[0] == '0 && deficit[NUM_PATHS-1] == '0)
    else $error("fallback did not clear deficits");

  a_no_path_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == wdps_pkg::ST_NO_ACTIVE || status == wdps_pkg::ST_PTR_RESET)
    |-> path_index == '0)
    else $error("path index set without a chosen path");

  a_charge_hit: assert property (@(posedge clk) disable iff (rst)
    state == wdps_pkg::S_CHARGE |-> acc > 0 && mask_q[idx])
    else $error("charge on a path that did not qualify");

endmodule
`default_nettype wire

[sv/wdps_cfg_regs.sv]
// APB-style weight register bank.
`default_nettype none
module wdps_cfg_regs (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [4:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic      [31:0]         prdata,
  output logic                     pready,
  output wdps_pkg::weight_arr_t    weights
);

  logic [2:0] reg_idx;

  assign reg_idx = paddr[4:2];
  assign pready  = 1'b1;
  assign prdata  = {22'b0, weights[reg_idx]};

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < wdps_pkg::NUM_WEIGHT_REGS; i++) begin
        weights[i] <= wdps_pkg::WEIGHT_W'(wdps_pkg::DEFAULT_WEIGHT);
      end
    end else if (psel && penable && pwrite && pready) begin
      weights[reg_idx] <= pwdata[wdps_pkg::WEIGHT_W-1:0];
    end
  end

endmodule
`default_nettype wire

[sv/wdps_alu.sv]
// Shared saturating 32-bit adder for deficit updates.
`default_nettype none
module wdps_alu (
  input  wire logic signed [31:0] a,
  input  wire logic signed [31:0] b,
  output logic signed [31:0]      sum
);

  logic signed [32:0] wide;

  assign wide = 33'(a) + 33'(b);

  always_comb begin
    if (wide > 33'sh0_7FFF_FFFF) begin
      sum = 32'sh7FFF_FFFF;
    end else if (wide < -33'sh0_8000_0000) begin
      sum = 32'sh8000_0000;
    end else begin
      sum = wide[31:0];
    end
  end

endmodule
`default_nettype wire
